### rtl/core/tatc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tatc_pkg
// Shared widths, constants and types for the thermistor ADC to temperature core.
// ----------------------------------------------------------------------------
package tatc_pkg;

	localparam int ADC_BITS      = 12;
	localparam int FRAC_BITS     = 8;
	localparam int TABLE_ENTRIES = 111;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int TEMP_W        = 16;
	localparam int QUO_W         = FRAC_BITS + 1;
	localparam int TEMP_LO       = -40;

	typedef logic [ADC_BITS-1:0]      adc_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [QUO_W-1:0]         quo_t;

	// first and last table entries, the clamp limits
	localparam adc_t ROM_FIRST = ADC_BITS'(3978);
	localparam adc_t ROM_LAST  = ADC_BITS'(607);
	localparam idx_t LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RD_UP,
		ST_RD_LO,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		adc_t num;
		adc_t den;
	} div_req_t;

	typedef struct packed {
		logic done;
		quo_t quo;
	} div_rsp_t;

endpackage
`default_nettype wire

### rtl/core/tatc_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tatc_rom
// Synchronous table of ADC codes, one per degree from -40 C to 70 C.
// ----------------------------------------------------------------------------
module tatc_rom (
	input  wire logic           clk,
	input  wire tatc_pkg::idx_t rd_addr,
	output tatc_pkg::adc_t      rd_data
);

	localparam tatc_pkg::adc_t NTC_ROM [0:tatc_pkg::TABLE_ENTRIES-1] = '{
		12'd3978, 12'd3970, 12'd3962, 12'd3953, 12'd3944, 12'd3935, 12'd3924, 12'd3914,
		12'd3902, 12'd3890, 12'd3878, 12'd3865, 12'd3851, 12'd3836, 12'd3821, 12'd3805,
		12'd3789, 12'd3771, 12'd3753, 12'd3734, 12'd3714, 12'd3694, 12'd3673, 12'd3650,
		12'd3627, 12'd3603, 12'd3578, 12'd3553, 12'd3526, 12'd3499, 12'd3470, 12'd3441,
		12'd3411, 12'd3379, 12'd3347, 12'd3314, 12'd3281, 12'd3246, 12'd3210, 12'd3174,
		12'd3137, 12'd3099, 12'd3060, 12'd3021, 12'd2981, 12'd2940, 12'd2898, 12'd2857,
		12'd2814, 12'd2771, 12'd2727, 12'd2683, 12'd2639, 12'd2594, 12'd2549, 12'd2504,
		12'd2458, 12'd2412, 12'd2367, 12'd2321, 12'd2275, 12'd2229, 12'd2184, 12'd2138,
		12'd2093, 12'd2048, 12'd2003, 12'd1958, 12'd1914, 12'd1870, 12'd1826, 12'd1783,
		12'd1741, 12'd1699, 12'd1657, 12'd1617, 12'd1576, 12'd1536, 12'd1497, 12'd1459,
		12'd1421, 12'd1384, 12'd1348, 12'd1312, 12'd1277, 12'd1242, 12'd1209, 12'd1176,
		12'd1144, 12'd1112, 12'd1082, 12'd1052, 12'd1022, 12'd994,  12'd966,  12'd939,
		12'd912,  12'd886,  12'd861,  12'd836,  12'd813,  12'd789,  12'd767,  12'd745,
		12'd723,  12'd703,  12'd682,  12'd663,  12'd644,  12'd625,  12'd607
	};

	tatc_pkg::adc_t rd_data_q;

	always_ff @(posedge clk) begin
		rd_data_q <= NTC_ROM[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/core/tatc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tatc_div
// Restoring radix-2 divider: floor(num * 2^FRAC_BITS / den) for num <= den.
// ----------------------------------------------------------------------------
module tatc_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tatc_pkg::div_req_t req,
	output tatc_pkg::div_rsp_t      rsp
);

	localparam int REM_W = tatc_pkg::ADC_BITS + 1;
	localparam int CNT_W = $clog2(tatc_pkg::QUO_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [REM_W-1:0]      rem_q;
	tatc_pkg::adc_t        den_q;
	tatc_pkg::quo_t        quo_q;

	logic                  ge;
	logic [REM_W-1:0]      rem_sub;

	// zero divisor yields a zero quotient
	assign ge      = (den_q != '0) && (rem_q >= {1'b0, den_q});
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(tatc_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[tatc_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

### rtl/core/thermistor_adc_to_temperature_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// NTC divider sample to degrees C (q8): table binary search plus linear
// interpolation with a serial divider.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  input    | in_valid / in_stall       | adc_sample
//  output   | out_valid / out_stall     | temperature_q8, below_range,
//           |                           | above_range, segment_index
//
//  one sample at a time; in_stall is high until the result is loaded
//  accept to next accept: a clamped sample goes from accept to output load;
//  an in-range sample takes the accept, 6 or 7 table probes at one read per
//  cycle, two reads for the segment bounds, the bit-serial divider and the
//  output register load, plus any time that register stays full under stall
//  arst_n clears the sequencer, the divider control and output valid only
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [tatc_pkg::ADC_BITS-1:0]     adc_sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [tatc_pkg::TEMP_W-1:0]     temperature_q8,
	output logic                                   below_range,
	output logic                                   above_range,
	output logic [tatc_pkg::IDX_W-1:0]             segment_index
);

	localparam int ONE = 1 << tatc_pkg::FRAC_BITS;

	function automatic tatc_pkg::idx_t mid_of(tatc_pkg::idx_t lo, tatc_pkg::idx_t hi);
		mid_of = lo + ((hi - lo) >> 1);
	endfunction

	tatc_pkg::state_t   state_q, state_d;
	tatc_pkg::adc_t     x_q, x_d;
	tatc_pkg::idx_t     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, seg_q, seg_d;
	tatc_pkg::adc_t     upper_q, upper_d;
	logic               below_q, below_d, above_q, above_d;
	tatc_pkg::quo_t     quo_q, quo_d;
	tatc_pkg::idx_t     lo_n, hi_n;

	tatc_pkg::idx_t     rom_addr;
	tatc_pkg::adc_t     rom_rd_data;
	tatc_pkg::div_req_t div_req;
	tatc_pkg::div_rsp_t div_rsp;

	logic               load_out;
	logic               out_valid_q;
	tatc_pkg::temp_t    base;
	tatc_pkg::temp_t    temp_d;
	tatc_pkg::temp_t    temp_q;
	logic               below_out_q, above_out_q;
	tatc_pkg::idx_t     seg_out_q;

	tatc_rom u_rom (
		.clk     (clk),
		.rd_addr (rom_addr),
		.rd_data (rom_rd_data)
	);

	tatc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall = (state_q != tatc_pkg::ST_IDLE);

	always_comb begin
		state_d  = state_q;
		x_d      = x_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		seg_d    = seg_q;
		upper_d  = upper_q;
		below_d  = below_q;
		above_d  = above_q;
		quo_d    = quo_q;
		lo_n     = lo_q;
		hi_n     = hi_q;
		rom_addr = mid_q;
		div_req  = '0;
		load_out = 1'b0;
		unique case (state_q)
			tatc_pkg::ST_IDLE: begin
				if (in_valid) begin
					x_d     = adc_sample;
					below_d = 1'b0;
					above_d = 1'b0;
					quo_d   = '0;
					if (adc_sample >= tatc_pkg::ROM_FIRST) begin
						below_d = 1'b1;
						seg_d   = '0;
						state_d = tatc_pkg::ST_DONE;
					end else if (adc_sample <= tatc_pkg::ROM_LAST) begin
						above_d = 1'b1;
						seg_d   = tatc_pkg::LAST_IDX;
						state_d = tatc_pkg::ST_DONE;
					end else begin
						lo_d     = tatc_pkg::IDX_W'(1);
						hi_d     = tatc_pkg::LAST_IDX;
						mid_d    = mid_of(tatc_pkg::IDX_W'(1), tatc_pkg::LAST_IDX);
						rom_addr = mid_d;
						state_d  = tatc_pkg::ST_SEARCH;
					end
				end
			end
			tatc_pkg::ST_SEARCH: begin
				// read data belongs to the probe issued last cycle
				if (rom_rd_data < x_q) begin
					hi_n = mid_q;
				end else begin
					lo_n = mid_q + tatc_pkg::IDX_W'(1);
				end
				lo_d = lo_n;
				hi_d = hi_n;
				if (lo_n < hi_n) begin
					mid_d    = mid_of(lo_n, hi_n);
					rom_addr = mid_d;
				end else begin
					seg_d    = lo_n;
					rom_addr = lo_n - tatc_pkg::IDX_W'(1);
					state_d  = tatc_pkg::ST_RD_UP;
				end
			end
			tatc_pkg::ST_RD_UP: begin
				upper_d  = rom_rd_data;
				rom_addr = seg_q;
				state_d  = tatc_pkg::ST_RD_LO;
			end
			tatc_pkg::ST_RD_LO: begin
				div_req.start = 1'b1;
				div_req.num   = x_q - rom_rd_data;
				div_req.den   = upper_q - rom_rd_data;
				state_d       = tatc_pkg::ST_DIV;
			end
			tatc_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					quo_d   = div_rsp.quo;
					state_d = tatc_pkg::ST_DONE;
				end
			end
			tatc_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = tatc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tatc_pkg::ST_IDLE;
			end
		endcase
	end

	// clamps carry a zero quotient, so the same formula covers them
	assign base   = tatc_pkg::TEMP_W'((int'(seg_q) + tatc_pkg::TEMP_LO) * ONE);
	assign temp_d = base - tatc_pkg::TEMP_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tatc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q     <= x_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		seg_q   <= seg_d;
		upper_q <= upper_d;
		below_q <= below_d;
		above_q <= above_d;
		quo_q   <= quo_d;
		if (load_out) begin
			temp_q      <= temp_d;
			below_out_q <= below_q;
			above_out_q <= above_q;
			seg_out_q   <= seg_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign temperature_q8 = temp_q;
	assign below_range    = below_out_q;
	assign above_range    = above_out_q;
	assign segment_index  = seg_out_q;

endmodule
`default_nettype wire
